// ----- hdl/oed_pkg.sv -----
`default_nettype none

package oed_pkg;

    localparam logic [7:0] BACKSLASH   = 8'h5C;
    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_SEVEN = 8'h37;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // One command holds every result byte caused by one input transaction.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            cnt;   // number of bytes minus one
        logic                        last;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/oed_front.sv -----
`default_nettype none

module oed_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output oed_pkg::cmd_t     cmd,
    output logic              push,
    output logic [1:0]        held_count
);

    logic [1:0]      held_reg;
    logic [1:0]      held_next;
    logic [1:0][2:0] digits_reg;
    logic [1:0][2:0] digits_next;
    logic [2:0]      n;
    logic            octal;
    logic [2:0]      d;

    assign octal      = (in_byte >= oed_pkg::DIGIT_ZERO) && (in_byte <= oed_pkg::DIGIT_SEVEN);
    assign d          = in_byte[2:0];
    assign held_count = held_reg;

    always_comb
    begin
        cmd         = '0;
        n           = 3'd0;
        held_next   = held_reg;
        digits_next = digits_reg;

        if ((held_reg != 2'd0) && octal)
        begin
            if (held_reg == 2'd3)
            begin
                cmd.bytes[0] = {digits_reg[0][1:0], digits_reg[1], d};
                n            = 3'd1;
                held_next    = 2'd0;
                digits_next  = '0;
            end
            else
            begin
                digits_next[held_reg[1]] = d;
                held_next                = held_reg + 2'd1;
            end
        end
        else
        begin
            if (held_reg >= 2'd1)
            begin
                cmd.bytes[0] = oed_pkg::BACKSLASH;
            end
            if (held_reg >= 2'd2)
            begin
                cmd.bytes[1] = oed_pkg::DIGIT_ZERO | {5'd0, digits_reg[0]};
            end
            if (held_reg == 2'd3)
            begin
                cmd.bytes[2] = oed_pkg::DIGIT_ZERO | {5'd0, digits_reg[1]};
            end
            n           = {1'b0, held_reg};
            held_next   = 2'd0;
            digits_next = '0;
            if (in_byte == oed_pkg::BACKSLASH)
            begin
                held_next = 2'd1;
            end
            else
            begin
                cmd.bytes[n[1:0]] = in_byte;
                n                 = n + 3'd1;
            end
        end

        if (in_last)
        begin
            if (held_next >= 2'd1)
            begin
                cmd.bytes[n[1:0]] = oed_pkg::BACKSLASH;
                n                 = n + 3'd1;
            end
            if (held_next >= 2'd2)
            begin
                cmd.bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'd0, digits_next[0]};
                n                 = n + 3'd1;
            end
            if (held_next == 2'd3)
            begin
                cmd.bytes[n[1:0]] = oed_pkg::DIGIT_ZERO | {5'd0, digits_next[1]};
                n                 = n + 3'd1;
            end
            held_next   = 2'd0;
            digits_next = '0;
        end

        cmd.cnt  = oed_pkg::CNT_W'(n - 3'd1);
        cmd.last = in_last;
        push     = accept && (n != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 2'd0;
            digits_reg <= '0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            digits_reg <= digits_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/oed_queue.sv -----
`default_nettype none

module oed_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire oed_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output oed_pkg::cmd_t      head,
    output logic               head_valid,
    output logic               full,
    output logic [1:0]         count
);

    oed_pkg::cmd_t mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/oed_back.sv -----
`default_nettype none

module oed_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire oed_pkg::cmd_t             head,
    input  wire logic                      head_valid,
    output logic                           pop,
    output logic [oed_pkg::CNT_W-1:0]      idx,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     out_byte,
    output logic                           out_last
);

    logic [oed_pkg::CNT_W-1:0] idx_reg;
    logic                      valid_reg;
    logic [7:0]                byte_reg;
    logic                      last_reg;
    logic                      load;
    logic                      at_end;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign at_end    = (idx_reg == head.cnt);
    assign pop       = load && at_end;
    assign idx       = idx_reg;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/octal_escape_decoder_core.sv -----
// The first result of a transaction passes through the command queue and the output register.
// Throughput: one input byte per cycle while each causes at most one result byte and m_axis_tready is high.
// A transaction that causes more than one result byte holds the output side until all are sent; a two-entry
// command queue between the classifier and the serializer absorbs this before s_axis stalls.
// Reset (rst_n, asynchronous, active low) clears held escape state, queue and output valid.
`default_nettype none

module octal_escape_decoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast
);

    oed_pkg::cmd_t              front_cmd;
    oed_pkg::cmd_t              head;
    logic                       push;
    logic                       pop;
    logic                       head_valid;
    logic                       full;
    logic [1:0]                 q_count;
    logic [1:0]                 held_count;
    logic [oed_pkg::CNT_W-1:0]  idx;
    logic                       accept;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    oed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .cmd        (front_cmd),
        .push       (push),
        .held_count (held_count)
    );

    oed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full),
        .count      (q_count)
    );

    oed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .idx        (idx),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx <= head.cnt)
        else $error("Serializer index beyond the command length.");

    a_last_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> held_count == 2'd0)
        else $error("Held escape bytes remain after a last transaction.");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count != 2'd3)
        else $error("Command queue overflow.");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx == '0)
        else $error("Serializer index not at zero with an empty queue.");

endmodule

`default_nettype wire

// ----- verif/octal_escape_decoder_core_tb.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] data;
    logic       last;
} decoded_beat_t;

class escape_scoreboard;
    decoded_beat_t decoded_bytes[$];
    logic [1:0]    held_count;
    logic [2:0]    held_digits[2];
    int            beats_made;
    int            errors;

    function new();
        held_count     = '0;
        held_digits[0] = '0;
        held_digits[1] = '0;
        beats_made     = 0;
        errors         = 0;
    endfunction

    task report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    function void push_decoded(input logic [7:0] value);
        decoded_beat_t beat;
        beat.data = value;
        beat.last = 1'b0;
        decoded_bytes.push_back(beat);
        beats_made++;
    endfunction

    function void release_held();
        int k;
        if (held_count != 0)
        begin
            push_decoded(oed_pkg::BACKSLASH);
            for (k = 0; k + 1 < held_count && k < 2; k++)
                push_decoded(oed_pkg::DIGIT_ZERO + {5'd0, held_digits[k]});
        end
        held_count     = '0;
        held_digits[0] = '0;
        held_digits[1] = '0;
    endfunction

    // Works out every byte one accepted input transaction gives rise to.
    function void note_input(input logic [7:0] in_byte, input logic in_last);
        logic       is_octal;
        logic [2:0] digit;
        logic [8:0] value;
        is_octal   = (in_byte >= oed_pkg::DIGIT_ZERO) && (in_byte <= oed_pkg::DIGIT_SEVEN);
        digit      = in_byte[2:0];
        beats_made = 0;
        if (held_count != 0 && is_octal)
        begin
            if (held_count == 3)
            begin
                value = {held_digits[0], held_digits[1], digit};
                push_decoded(value[7:0]);
                held_count     = '0;
                held_digits[0] = '0;
                held_digits[1] = '0;
            end
            else
            begin
                held_digits[held_count - 2'd1] = digit;
                held_count = held_count + 2'd1;
            end
        end
        else
        begin
            release_held();
            if (in_byte == oed_pkg::BACKSLASH)
                held_count = 2'd1;
            else
                push_decoded(in_byte);
        end
        if (in_last)
        begin
            release_held();
            if (beats_made > 0)
                decoded_bytes[decoded_bytes.size() - 1].last = 1'b1;
        end
    endfunction

    task check_output(input logic [7:0] out_byte, input logic out_last);
        decoded_beat_t want;
        if (decoded_bytes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                      out_byte, out_last));
            return;
        end
        want = decoded_bytes.pop_front();
        if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                      out_last, want.last, want.data));
    endtask

    function int outstanding();
        return decoded_bytes.size();
    endfunction
endclass

module octal_escape_decoder_core_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_ITEMS   = 60;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    escape_scoreboard sb = new();
    int               cycles = 0;
    int               sent = 0;
    int               stall_left = 0;
    bit               quiet = 1'b0;

    octal_escape_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("octal_escape_decoder_core_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata, m_axis_tlast);
    end

    // The receiver stalls in bursts of random length at random times.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 8);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] in_byte, input logic in_last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = in_byte;
        s_axis_tlast  = in_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(in_byte, in_last);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] octal_char();
        return 8'(oed_pkg::DIGIT_ZERO + $urandom_range(0, 7));
    endfunction

    task automatic send_random_run();
        logic [7:0] run_bytes[$];
        int         n;
        int         k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                run_bytes.push_back(oed_pkg::BACKSLASH);
                repeat (3) run_bytes.push_back(octal_char());
            end
            4:
            begin
                run_bytes.push_back(oed_pkg::BACKSLASH);
                n = $urandom_range(0, 2);
                repeat (n) run_bytes.push_back(octal_char());
                run_bytes.push_back(8'($urandom_range(0, 255)));
            end
            5:
            begin
                run_bytes.push_back(oed_pkg::BACKSLASH);
                case ($urandom_range(0, 3))
                    0: run_bytes.push_back(oed_pkg::BACKSLASH);
                    1: run_bytes.push_back(oed_pkg::DIGIT_SEVEN + 8'd1);
                    2: run_bytes.push_back(oed_pkg::DIGIT_ZERO - 8'd1);
                    default: run_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            default:
                run_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
        for (k = 0; k < run_bytes.size(); k++)
            send_byte(run_bytes[k], $urandom_range(0, 11) == 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte("1", 1'b0);
        send_byte("0", 1'b0);
        send_byte("1", 1'b0);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte(oed_pkg::DIGIT_SEVEN, 1'b0);
        send_byte(oed_pkg::DIGIT_SEVEN, 1'b0);
        send_byte(oed_pkg::DIGIT_SEVEN, 1'b1);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte("1", 1'b0);
        send_byte("2", 1'b0);
        send_byte("x", 1'b0);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte("8", 1'b0);
        send_byte(oed_pkg::BACKSLASH, 1'b1);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte("3", 1'b1);
        send_byte(oed_pkg::BACKSLASH, 1'b0);
        send_byte(oed_pkg::DIGIT_ZERO, 1'b0);
        send_byte(oed_pkg::DIGIT_ZERO, 1'b0);
        send_byte("/", 1'b1);
        send_byte("a", 1'b1);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_run();
        end
        send_byte("z", 1'b1);
        s_axis_tvalid = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d expected bytes never arrived",
                                         sb.outstanding()));
        if (sb.errors == 0)
            $display("octal_escape_decoder_core_tb passed");
        else
            $display("octal_escape_decoder_core_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/oed_pkg.sv
hdl/oed_front.sv
hdl/oed_queue.sv
hdl/oed_back.sv
hdl/octal_escape_decoder_core.sv
verif/octal_escape_decoder_core_tb.sv
